/* hdl/htc_pkg.sv */
// Shared types and constants for the hysteresis thermostat controller.
`timescale 1ns / 1ps
`default_nettype none
package htc_pkg;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_SAMPLE      = 3'd1,
        OP_DOWN        = 3'd2,
        OP_UP          = 3'd3,
        OP_MODE_BUTTON = 3'd4,
        OP_SETPOINT    = 3'd5,
        OP_HEATER      = 3'd6,
        OP_MODE        = 3'd7
    } op_t;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;

    localparam logic [1:0] KIND_ABS = 2'd0;
    localparam logic [1:0] KIND_ADD = 2'd1;
    localparam logic [1:0] KIND_SUB = 2'd2;

    localparam logic [1:0] REQ_OFF    = 2'd0;
    localparam logic [1:0] REQ_ON     = 2'd1;
    localparam logic [1:0] REQ_TOGGLE = 2'd2;
    localparam logic [1:0] HELD_NONE  = 2'd3;

    localparam logic [1:0] REG_HYST   = 2'd0;
    localparam logic [1:0] REG_DELAY  = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;
    localparam logic [1:0] REG_INVERT = 2'd3;

    localparam logic [6:0]  HYST_RESET  = 7'd5;
    localparam logic [7:0]  DELAY_RESET = 8'd0;
    localparam logic [12:0] STEP_RESET  = 13'd300;

    localparam logic signed [11:0] SETPOINT_RESET = 12'sd200;
    localparam logic signed [12:0] SETPOINT_MIN   = -13'sd1000;
    localparam logic signed [12:0] SETPOINT_MAX   = 13'sd1500;
    localparam logic signed [12:0] SETPOINT_STEP  = 13'sd5;

    localparam logic [12:0] SECONDS_PER_MINUTE  = 13'd60;
    localparam logic [12:0] MODE_BUTTON_SECONDS = 13'd300;

    // decoded word passed from the front end to the execute stage
    typedef struct packed {
        op_t               op;
        logic signed [11:0] value;
        logic [1:0]        kind;
        logic [1:0]        req;
        logic [1:0]        nmode;
        logic [12:0]       seconds;
    } htc_cmd_t;

    typedef struct packed {
        logic              heater_on;
        logic              relay_drive;
        logic [1:0]        mode_now;
        logic signed [11:0] setpoint_now;
        logic [12:0]       seconds_left;
        logic              report_now;
    } htc_rsp_t;

endpackage
`default_nettype wire

/* hdl/htc_if.sv */
// Valid/ready channel interfaces for event words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface htc_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic signed [11:0] value_tenths;
    logic [1:0]        setpoint_kind;
    logic [1:0]        heater_request;
    logic [1:0]        new_mode;
    logic [6:0]        manual_minutes;

    modport source (output valid, operation, value_tenths, setpoint_kind,
                    heater_request, new_mode, manual_minutes, input ready);
    modport sink (input valid, operation, value_tenths, setpoint_kind,
                  heater_request, new_mode, manual_minutes, output ready);
endinterface

interface htc_out_if;
    logic              valid;
    logic              ready;
    logic              heater_on;
    logic              relay_drive;
    logic [1:0]        mode_now;
    logic signed [11:0] setpoint_now;
    logic [12:0]       seconds_left;
    logic              report_now;

    modport source (output valid, heater_on, relay_drive, mode_now, setpoint_now,
                    seconds_left, report_now, input ready);
    modport sink (input valid, heater_on, relay_drive, mode_now, setpoint_now,
                  seconds_left, report_now, output ready);
endinterface
`default_nettype wire

/* hdl/htc_front.sv */
// Front end: accepts event words and decodes them into command words.
`timescale 1ns / 1ps
`default_nettype none
module htc_front
    import htc_pkg::*;
#(
    parameter int MANUAL_MAX_SECONDS = 5400
) (
    htc_in_if.sink    cmd,
    output logic      q_valid,
    input  wire logic q_ready,
    output htc_cmd_t  q_data
);

    localparam logic [12:0] MAX_SECONDS = 13'(MANUAL_MAX_SECONDS);

    logic [12:0] minute_seconds;
    logic [12:0] raw_seconds;

    assign cmd.ready = q_ready;
    assign q_valid   = cmd.valid;

    // 127 minutes still fits in 13 bits before saturation
    assign minute_seconds = {6'd0, cmd.manual_minutes} * SECONDS_PER_MINUTE;

    always_comb
    begin
        q_data.op    = op_t'(cmd.operation);
        q_data.value = cmd.value_tenths;
        q_data.kind  = (cmd.setpoint_kind == KIND_ADD || cmd.setpoint_kind == KIND_SUB)
                     ? cmd.setpoint_kind : KIND_ABS;
        q_data.req   = (cmd.heater_request == REQ_ON || cmd.heater_request == REQ_TOGGLE)
                     ? cmd.heater_request : REQ_OFF;
        q_data.nmode = cmd.new_mode;
        raw_seconds  = (op_t'(cmd.operation) == OP_MODE) ? minute_seconds
                     : MODE_BUTTON_SECONDS;
        q_data.seconds = (raw_seconds > MAX_SECONDS) ? MAX_SECONDS : raw_seconds;
    end

endmodule
`default_nettype wire

/* hdl/htc_queue.sv */
// Two-entry command queue between the front end and the execute stage.
`timescale 1ns / 1ps
`default_nettype none
module htc_queue
    import htc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire htc_cmd_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output htc_cmd_t       out_data
);

    htc_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == 2'($past(count_reg) + 2'd1))
        else $error("queue count did not follow push");

    a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == 2'($past(count_reg) - 2'd1))
        else $error("queue count did not follow pop");

endmodule
`default_nettype wire

/* hdl/htc_back.sv */
// Execute stage: thermostat state, configuration registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module htc_back
    import htc_pkg::*;
#(
    parameter int MANUAL_MAX_SECONDS = 5400
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire htc_cmd_t    q_data,
    htc_out_if.source        rsp
);

    localparam logic [12:0] MAX_SECONDS = 13'(MANUAL_MAX_SECONDS);

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [11:0] setpoint;
        logic              heater;
        logic [12:0]       manual_left;
        logic [7:0]        delay_left;
        logic [1:0]        held;
        logic signed [11:0] last_temp;
        logic              sample_seen;
        logic              changed;
    } ctl_state_t;

    logic [6:0]  hyst_reg;
    logic [7:0]  delay_cfg_reg;
    logic [12:0] step_reg;
    logic        invert_reg;

    ctl_state_t st_reg;
    ctl_state_t st_next;
    logic       report;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    htc_rsp_t   rsp_reg;
    logic       pop;

    function automatic logic apply_req(input logic h, input logic [1:0] r);
        logic res;
        case (r)
            REQ_ON:     res = 1'b1;
            REQ_TOGGLE: res = ~h;
            default:    res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic ctl_state_t set_heater(input ctl_state_t s, input logic [1:0] r);
        ctl_state_t n;
        n = s;
        if (s.delay_left == 8'd0)
        begin
            n.heater = apply_req(s.heater, r);
            n.held   = HELD_NONE;
        end
        else
        begin
            n.held = r;
        end
        return n;
    endfunction

    function automatic ctl_state_t auto_check(input ctl_state_t s,
                                              input logic signed [11:0] temp);
        ctl_state_t n;
        logic signed [12:0] t13;
        logic signed [12:0] sp13;
        logic signed [12:0] off13;
        n     = s;
        t13   = 13'(temp);
        sp13  = 13'($signed(s.setpoint));
        off13 = t13 - $signed({6'd0, hyst_reg});
        if (s.mode == MODE_AUTO && s.sample_seen && temp != 12'sd0)
        begin
            if (sp13 > t13 && !s.heater)
            begin
                n.changed = 1'b1;
                n = set_heater(n, REQ_ON);
            end
            else if (off13 >= sp13 && s.heater)
            begin
                n.changed = 1'b1;
                n = set_heater(n, REQ_OFF);
            end
        end
        return n;
    endfunction

    function automatic ctl_state_t set_mode(input ctl_state_t s, input logic [1:0] m,
                                            input logic [12:0] secs);
        ctl_state_t n;
        n = s;
        n.manual_left = 13'd0;
        case (m)
            MODE_OFF:
            begin
                n.mode = MODE_OFF;
                n = set_heater(n, REQ_OFF);
            end
            MODE_AUTO:
            begin
                n.mode = MODE_AUTO;
            end
            MODE_MANUAL:
            begin
                n.mode = MODE_MANUAL;
                n.manual_left = secs;
                n = set_heater(n, REQ_ON);
            end
            default:
            begin
                // unused mode code: off, heater left alone
                n.mode = MODE_OFF;
            end
        endcase
        return n;
    endfunction

    function automatic ctl_state_t change_setpoint(input ctl_state_t s,
                                                   input logic signed [12:0] v);
        ctl_state_t n;
        logic signed [12:0] sat;
        n   = s;
        sat = v;
        if (v < SETPOINT_MIN)
        begin
            sat = SETPOINT_MIN;
        end
        if (v > SETPOINT_MAX)
        begin
            sat = SETPOINT_MAX;
        end
        if (s.mode == MODE_AUTO && sat[11:0] != s.setpoint)
        begin
            n.changed    = 1'b1;
            n.delay_left = delay_cfg_reg;
        end
        n.setpoint = sat[11:0];
        return n;
    endfunction

    function automatic logic [12:0] step_manual(input logic [12:0] t, input logic up);
        logic [13:0] sum;
        logic [12:0] res;
        sum = {1'b0, t} + {1'b0, step_reg};
        if (up)
        begin
            res = (sum > {1'b0, MAX_SECONDS}) ? SECONDS_PER_MINUTE : sum[12:0];
        end
        else
        begin
            res = (step_reg > t) ? MAX_SECONDS : (t - step_reg);
        end
        return res;
    endfunction

    assign pop     = q_valid && q_ready;
    assign q_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        logic signed [12:0] sp13;
        logic signed [12:0] val13;
        logic               was_on;
        logic [1:0]         held;
        st_next = st_reg;
        report  = 1'b0;
        was_on  = st_reg.heater;
        held    = st_reg.held;
        sp13    = 13'($signed(st_reg.setpoint));
        val13   = 13'(q_data.value);
        case (q_data.op)
            OP_TICK:
            begin
                if (st_next.mode == MODE_MANUAL)
                begin
                    if (st_next.manual_left != 13'd0)
                    begin
                        st_next.manual_left = st_next.manual_left - 13'd1;
                    end
                    else
                    begin
                        st_next = set_mode(st_next, MODE_AUTO, 13'd0);
                        st_next = auto_check(st_next, st_next.last_temp);
                    end
                end
                if (st_next.delay_left != 8'd0)
                begin
                    st_next.delay_left = st_next.delay_left - 8'd1;
                    held = st_next.held;
                    if (st_next.delay_left == 8'd0 && held != HELD_NONE)
                    begin
                        st_next.held   = HELD_NONE;
                        st_next.heater = apply_req(st_next.heater, held);
                    end
                end
                else
                begin
                    st_next = auto_check(st_next, st_next.last_temp);
                end
                report = st_next.changed;
                st_next.changed = 1'b0;
            end
            OP_SAMPLE:
            begin
                st_next = auto_check(st_next, q_data.value);
                st_next.last_temp   = q_data.value;
                st_next.sample_seen = 1'b1;
            end
            OP_DOWN, OP_UP:
            begin
                if (st_reg.mode == MODE_AUTO)
                begin
                    st_next = change_setpoint(st_next, (q_data.op == OP_UP)
                                              ? sp13 + SETPOINT_STEP : sp13 - SETPOINT_STEP);
                end
                else if (st_reg.mode == MODE_MANUAL)
                begin
                    st_next.manual_left = step_manual(st_reg.manual_left,
                                                      q_data.op == OP_UP);
                end
            end
            OP_MODE_BUTTON:
            begin
                if (st_reg.mode == MODE_OFF)
                begin
                    st_next = set_mode(st_next, MODE_AUTO, 13'd0);
                end
                else if (st_reg.mode == MODE_AUTO)
                begin
                    st_next = set_mode(st_next, MODE_MANUAL, q_data.seconds);
                end
                else
                begin
                    st_next = set_mode(st_next, MODE_OFF, 13'd0);
                end
            end
            OP_SETPOINT:
            begin
                case (q_data.kind)
                    KIND_ADD: st_next = change_setpoint(st_next, sp13 + val13);
                    KIND_SUB: st_next = change_setpoint(st_next, sp13 - val13);
                    default:  st_next = change_setpoint(st_next, val13);
                endcase
                st_next = auto_check(st_next, st_next.last_temp);
            end
            OP_HEATER:
            begin
                was_on  = st_reg.heater;
                st_next = set_heater(st_next, q_data.req);
                if (was_on != st_next.heater)
                begin
                    st_next.changed = 1'b1;
                end
            end
            default:
            begin
                st_next = set_mode(st_next, q_data.nmode, q_data.seconds);
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (pop)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg      <= HYST_RESET;
            delay_cfg_reg <= DELAY_RESET;
            step_reg      <= STEP_RESET;
            invert_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HYST:   hyst_reg      <= cfg_data[6:0];
                REG_DELAY:  delay_cfg_reg <= cfg_data[7:0];
                REG_STEP:   step_reg      <= cfg_data;
                REG_INVERT: invert_reg    <= cfg_data[0];
                default:    hyst_reg      <= hyst_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode        <= MODE_AUTO;
            st_reg.setpoint    <= SETPOINT_RESET;
            st_reg.heater      <= 1'b0;
            st_reg.manual_left <= 13'd0;
            st_reg.delay_left  <= 8'd0;
            st_reg.held        <= HELD_NONE;
            st_reg.last_temp   <= 12'sd0;
            st_reg.sample_seen <= 1'b0;
            st_reg.changed     <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                st_reg <= st_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsp_reg.heater_on    <= st_next.heater;
            rsp_reg.relay_drive  <= st_next.heater ^ invert_reg;
            rsp_reg.mode_now     <= st_next.mode;
            rsp_reg.setpoint_now <= st_next.setpoint;
            rsp_reg.seconds_left <= st_next.manual_left;
            rsp_reg.report_now   <= report;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.heater_on    = rsp_reg.heater_on;
    assign rsp.relay_drive  = rsp_reg.relay_drive;
    assign rsp.mode_now     = rsp_reg.mode_now;
    assign rsp.setpoint_now = rsp_reg.setpoint_now;
    assign rsp.seconds_left = rsp_reg.seconds_left;
    assign rsp.report_now   = rsp_reg.report_now;

    a_timer_only_manual: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode != MODE_MANUAL |-> st_reg.manual_left == 13'd0)
        else $error("manual timer running outside manual mode");

    a_setpoint_range: assert property (@(posedge clk) disable iff (!rst_n)
        $signed(st_reg.setpoint) >= -12'sd1000 && $signed(st_reg.setpoint) <= 12'sd1500)
        else $error("setpoint outside saturation range");

    a_timer_max: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.manual_left <= MAX_SECONDS)
        else $error("manual timer above maximum");

endmodule
`default_nettype wire

/* hdl/hysteresis_thermostat_controller.sv */
// Top level of the on/off heater thermostat with hysteresis.
//
// cmd carries one event word per handshake: a tick, a temperature sample, a
// button press or a setpoint, heater or mode command. rsp returns exactly one
// word per event with heater state, relay level, mode, setpoint, manual time
// left and, on ticks, the publish flag.
// cfg_we/cfg_index/cfg_data write the four configuration registers, one
// register per write; write them only while no event is in flight.
// A word accepted on cmd is written into the queue entry and then into the
// result register before it shows on rsp. Throughput: one word per cycle
// while rsp does not stall, set by the execute stage that updates the whole
// thermostat state per word. A two-entry queue separates decode from execute
// and a result register drives rsp; when rsp stalls the queue fills and
// cmd.ready drops after two more words. Reset puts auto mode, setpoint 20.0
// degrees, heater off and default configuration in place.
`timescale 1ns / 1ps
`default_nettype none
module hysteresis_thermostat_controller
    import htc_pkg::*;
#(
    parameter int MANUAL_MAX_SECONDS = 5400
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    htc_in_if.sink           cmd,
    htc_out_if.source        rsp
);

    logic     fq_valid;
    logic     fq_ready;
    htc_cmd_t fq_data;
    logic     qb_valid;
    logic     qb_ready;
    htc_cmd_t qb_data;

    htc_front #(
        .MANUAL_MAX_SECONDS(MANUAL_MAX_SECONDS)
    ) u_front (
        .cmd     (cmd),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    htc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    htc_back #(
        .MANUAL_MAX_SECONDS(MANUAL_MAX_SECONDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

/* dv/hysteresis_thermostat_controller_tb.sv */
// Self-checking testbench for the hysteresis thermostat controller.
`timescale 1ns / 1ps
module hysteresis_thermostat_controller_tb;
    import htc_pkg::*;

    localparam int MANUAL_MAX_SECONDS  = 5400;
    localparam int SETTLE_CYCLES       = 4;
    localparam int MAX_REPORTED        = 10;
    localparam logic [1:0] KIND_OTHER  = 2'd3;
    localparam logic [1:0] REQ_OTHER   = 2'd3;
    localparam logic [1:0] MODE_OTHER  = 2'd3;

    typedef struct {
        op_t                op;
        logic signed [11:0] value;
        logic [1:0]         kind;
        logic [1:0]         req;
        logic [1:0]         nmode;
        logic [6:0]         minutes;
    } cmd_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    htc_in_if  cmd_if ();
    htc_out_if rsp_if ();

    hysteresis_thermostat_controller #(
        .MANUAL_MAX_SECONDS(MANUAL_MAX_SECONDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd_if),
        .rsp      (rsp_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // thermostat state tracked by the testbench
    int         hyst_cfg;
    int         hold_cfg;
    int         step_cfg;
    bit         invert_cfg;
    logic [1:0] mode_st;
    int         setpoint_st;
    bit         heater_st;
    int         manual_st;
    int         hold_st;
    logic [1:0] held_req_st;
    int         last_temp_st;
    bit         sample_seen_st;
    bit         changed_st;

    htc_rsp_t    expected_rsp[$];
    int          mismatches = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int          rx_stall_left = 0;

    function automatic void reset_thermostat();
        hyst_cfg       = HYST_RESET;
        hold_cfg       = DELAY_RESET;
        step_cfg       = STEP_RESET;
        invert_cfg     = 1'b0;
        mode_st        = MODE_AUTO;
        setpoint_st    = SETPOINT_RESET;
        heater_st      = 1'b0;
        manual_st      = 0;
        hold_st        = 0;
        held_req_st    = HELD_NONE;
        last_temp_st   = 0;
        sample_seen_st = 1'b0;
        changed_st     = 1'b0;
    endfunction

    function automatic void apply_request(logic [1:0] r);
        if (r == REQ_ON)
            heater_st = 1'b1;
        else if (r == REQ_TOGGLE)
            heater_st = !heater_st;
        else
            heater_st = 1'b0;
    endfunction

    function automatic void request_heater(logic [1:0] r);
        if (r == REQ_OTHER)
            r = REQ_OFF;
        if (hold_st == 0)
        begin
            apply_request(r);
            held_req_st = HELD_NONE;
        end
        else
            held_req_st = r;   // latest request wins when the hold ends
    endfunction

    function automatic void auto_switch(int temp);
        if (mode_st != MODE_AUTO || !sample_seen_st || temp == 0)
            return;
        if (setpoint_st > temp && !heater_st)
        begin
            changed_st = 1'b1;
            request_heater(REQ_ON);
        end
        else if (temp - hyst_cfg >= setpoint_st && heater_st)
        begin
            changed_st = 1'b1;
            request_heater(REQ_OFF);
        end
    endfunction

    function automatic void enter_mode(logic [1:0] m, int seconds);
        manual_st = 0;
        case (m)
            MODE_OFF:
            begin
                mode_st = MODE_OFF;
                request_heater(REQ_OFF);
            end
            MODE_AUTO:
                mode_st = MODE_AUTO;
            MODE_MANUAL:
            begin
                mode_st   = MODE_MANUAL;
                manual_st = (seconds > MANUAL_MAX_SECONDS) ? MANUAL_MAX_SECONDS : seconds;
                request_heater(REQ_ON);
            end
            default:
                mode_st = MODE_OFF;   // heater left alone
        endcase
    endfunction

    function automatic void move_setpoint(int v);
        if (v < SETPOINT_MIN)
            v = SETPOINT_MIN;
        if (v > SETPOINT_MAX)
            v = SETPOINT_MAX;
        if (mode_st == MODE_AUTO && v != setpoint_st)
        begin
            changed_st = 1'b1;
            hold_st    = hold_cfg;
        end
        setpoint_st = v;
    endfunction

    function automatic void step_timer(bit up);
        int t;
        t = manual_st;
        if (up)
        begin
            t += step_cfg;
            if (t > MANUAL_MAX_SECONDS)
                t = SECONDS_PER_MINUTE;
        end
        else
        begin
            t -= step_cfg;
            if (t < 0)
                t = MANUAL_MAX_SECONDS;
        end
        manual_st = t;
    endfunction

    function automatic htc_rsp_t thermostat_step(cmd_word_t w);
        htc_rsp_t r;
        bit       report_bit;
        bit       was_on;
        int       val;
        report_bit = 1'b0;
        val        = w.value;
        case (w.op)
            OP_TICK:
            begin
                if (mode_st == MODE_MANUAL)
                begin
                    if (manual_st > 0)
                        manual_st--;
                    else
                    begin
                        enter_mode(MODE_AUTO, 0);
                        auto_switch(last_temp_st);
                    end
                end
                if (hold_st > 0)
                begin
                    hold_st--;
                    if (hold_st == 0 && held_req_st != HELD_NONE)
                    begin
                        apply_request(held_req_st);
                        held_req_st = HELD_NONE;
                    end
                end
                else
                    auto_switch(last_temp_st);
                report_bit = changed_st;
                changed_st = 1'b0;
            end
            OP_SAMPLE:
            begin
                auto_switch(val);
                last_temp_st   = val;
                sample_seen_st = 1'b1;
            end
            OP_DOWN, OP_UP:
            begin
                if (mode_st == MODE_AUTO)
                    move_setpoint(setpoint_st + ((w.op == OP_UP) ? int'(SETPOINT_STEP)
                                                                 : -int'(SETPOINT_STEP)));
                else if (mode_st == MODE_MANUAL)
                    step_timer(w.op == OP_UP);
            end
            OP_MODE_BUTTON:
            begin
                if (mode_st == MODE_OFF)
                    enter_mode(MODE_AUTO, 0);
                else if (mode_st == MODE_AUTO)
                    enter_mode(MODE_MANUAL, MODE_BUTTON_SECONDS);
                else
                    enter_mode(MODE_OFF, 0);
            end
            OP_SETPOINT:
            begin
                if (w.kind == KIND_ADD)
                    move_setpoint(setpoint_st + val);
                else if (w.kind == KIND_SUB)
                    move_setpoint(setpoint_st - val);
                else
                    move_setpoint(val);
                auto_switch(last_temp_st);
            end
            OP_HEATER:
            begin
                was_on = heater_st;
                request_heater(w.req);
                if (was_on != heater_st)
                    changed_st = 1'b1;
            end
            default:
                enter_mode(w.nmode, int'(w.minutes) * int'(SECONDS_PER_MINUTE));
        endcase
        r.heater_on    = heater_st;
        r.relay_drive  = heater_st ^ invert_cfg;
        r.mode_now     = mode_st;
        r.setpoint_now = setpoint_st[11:0];
        r.seconds_left = manual_st[12:0];
        r.report_now   = report_bit;
        return r;
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("%t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic signed [13:0] want,
                                        logic signed [13:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    function automatic cmd_word_t word_for(op_t op, int value = 0,
                                           logic [1:0] kind = KIND_ABS,
                                           logic [1:0] req = REQ_OFF,
                                           logic [1:0] nmode = MODE_OFF,
                                           int minutes = 0);
        cmd_word_t w;
        w.op      = op;
        w.value   = 12'(value);
        w.kind    = kind;
        w.req     = req;
        w.nmode   = nmode;
        w.minutes = 7'(minutes);
        return w;
    endfunction

    // mostly plausible traffic: samples near the setpoint, short manual runs
    function automatic cmd_word_t random_word();
        cmd_word_t   w;
        int unsigned pick;
        w.value   = 12'($urandom);
        w.kind    = 2'($urandom);
        w.req     = 2'($urandom);
        w.nmode   = 2'($urandom);
        w.minutes = 7'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 30)
            w.op = OP_TICK;
        else if (pick < 55)
        begin
            w.op = OP_SAMPLE;
            if (pick < 51)
                w.value = 12'(setpoint_st + int'($urandom_range(0, 240)) - 120);
            else if (pick < 53)
                w.value = 12'sd0;
        end
        else if (pick < 65)
            w.op = (pick < 60) ? OP_DOWN : OP_UP;
        else if (pick < 69)
            w.op = OP_MODE_BUTTON;
        else if (pick < 80)
        begin
            w.op = OP_SETPOINT;
            if (w.kind != KIND_ABS && pick < 77)
                w.value = 12'(int'($urandom_range(0, 100)) - 50);
            else if (pick < 76)
                w.value = 12'(int'($urandom_range(0, 3000)) - 1500);
        end
        else if (pick < 92)
            w.op = OP_HEATER;
        else
        begin
            w.op = OP_MODE;
            if (pick < 98)
                w.minutes = 7'($urandom_range(0, 2));
        end
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(cmd_word_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.operation      <= w.op;
        cmd_if.value_tenths   <= w.value;
        cmd_if.setpoint_kind  <= w.kind;
        cmd_if.heater_request <= w.req;
        cmd_if.new_mode       <= w.nmode;
        cmd_if.manual_minutes <= w.minutes;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        expected_rsp.push_back(thermostat_step(w));
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(int hyst, int hold, int step, bit invert);
        logic [12:0] values [4];
        values = '{hyst[12:0], hold[12:0], step[12:0], {12'd0, invert}};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= values[i];
            @(posedge clk);
            case (i[1:0])
                REG_HYST:  hyst_cfg   = values[i][6:0];
                REG_DELAY: hold_cfg   = values[i][7:0];
                REG_STEP:  step_cfg   = values[i][12:0];
                default:   invert_cfg = values[i][0];
            endcase
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_word(word_for(OP_TICK));
    endtask

    task automatic test_auto_switching();
        send_word(word_for(OP_SAMPLE, 150));    // first sample never switches
        send_word(word_for(OP_SAMPLE, 0));      // zero reading ignored
        send_word(word_for(OP_SAMPLE, 150));
        send_word(word_for(OP_TICK));
        send_word(word_for(OP_SAMPLE, 205));    // exactly setpoint plus margin
        send_word(word_for(OP_SAMPLE, 204));
        send_word(word_for(OP_SAMPLE, -2048));
        send_word(word_for(OP_SAMPLE, 2047));
        send_word(word_for(OP_TICK));
    endtask

    task automatic test_setpoint_edits();
        configure(0, 0, 300, 1'b1);
        send_word(word_for(OP_SETPOINT, 2047, KIND_ABS));
        send_word(word_for(OP_SETPOINT, -2048, KIND_ADD));
        send_word(word_for(OP_SETPOINT, -2048, KIND_SUB));
        send_word(word_for(OP_SETPOINT, -1500, KIND_OTHER));
        send_word(word_for(OP_SETPOINT, -1000, KIND_ABS));   // unchanged: no hold
        send_word(word_for(OP_DOWN));
        send_word(word_for(OP_UP));
    endtask

    task automatic test_holds_and_requests();
        configure(100, 2, 300, 1'b0);
        send_word(word_for(OP_SAMPLE, 300));
        send_word(word_for(OP_SETPOINT, 400, KIND_ABS));     // starts a two-tick hold
        send_word(word_for(OP_HEATER, 0, KIND_ABS, REQ_OTHER));
        send_word(word_for(OP_HEATER, 0, KIND_ABS, REQ_TOGGLE));
        send_word(word_for(OP_TICK));
        send_word(word_for(OP_TICK));
        send_word(word_for(OP_MODE, 0, KIND_ABS, REQ_OFF, MODE_OTHER));
        repeat (3) send_word(word_for(OP_MODE_BUTTON));
    endtask

    task automatic test_manual_timer();
        configure(5, 0, 300, 1'b0);
        send_word(word_for(OP_MODE, 0, KIND_ABS, REQ_OFF, MODE_MANUAL, 127));
        send_word(word_for(OP_UP));      // wraps to one minute
        send_word(word_for(OP_DOWN));    // wraps to the maximum
        send_word(word_for(OP_MODE, 0, KIND_ABS, REQ_OFF, MODE_MANUAL, 0));
        send_word(word_for(OP_TICK));    // expired: back to auto
        configure(5, 0, 0, 1'b0);
        send_word(word_for(OP_MODE, 0, KIND_ABS, REQ_OFF, MODE_MANUAL, 1));
        send_word(word_for(OP_UP));
        send_word(word_for(OP_MODE, 0, KIND_ABS, REQ_OFF, MODE_OFF));
        send_word(word_for(OP_UP));
    endtask

    task automatic run_random(int count, int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_word(random_word());
    endtask

    task automatic test_backpressure();
        drain();
        @(posedge clk);
        rx_stall_left = 80;
        @(negedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (24) send_word(random_word());
        drain();
    endtask

    task automatic test_random_traffic();
        configure(0, 3, 1, 1'b1);
        run_random(150, 31, 49);
        configure(100, 255, 5400, 1'b0);
        run_random(75, 49, 31);
        drain();
        run_random(75, 49, 31);
        test_backpressure();
        configure(17, 1, 2500, 1'b1);
        run_random(90, 0, 0);
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                rx_stall_left--;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        htc_rsp_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_rsp.size() == 0)
                note_failure("result word with nothing expected");
            else
            begin
                want = expected_rsp.pop_front();
                check_field("heater_on", want.heater_on, rsp_if.heater_on);
                check_field("relay_drive", want.relay_drive, rsp_if.relay_drive);
                check_field("mode_now", want.mode_now, rsp_if.mode_now);
                check_field("setpoint_now", want.setpoint_now, rsp_if.setpoint_now);
                check_field("seconds_left", want.seconds_left, rsp_if.seconds_left);
                check_field("report_now", want.report_now, rsp_if.report_now);
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_HYST;
        cfg_data              = '0;
        cmd_if.valid          = 1'b0;
        cmd_if.operation      = OP_TICK;
        cmd_if.value_tenths   = '0;
        cmd_if.setpoint_kind  = KIND_ABS;
        cmd_if.heater_request = REQ_OFF;
        cmd_if.new_mode       = MODE_OFF;
        cmd_if.manual_minutes = '0;
        reset_thermostat();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_auto_switching();
        test_setpoint_edits();
        test_holds_and_requests();
        test_manual_timer();
        test_random_traffic();

        drain();
        repeat (8) @(posedge clk);
        if (expected_rsp.size() != 0)
            note_failure($sformatf("%0d result words never arrived", expected_rsp.size()));
        if (mismatches == 0)
            $display("hysteresis_thermostat_controller_tb: PASS");
        else
            $display("hysteresis_thermostat_controller_tb: FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("hysteresis_thermostat_controller_tb: FAIL");
        $finish;
    end

endmodule
